// File: rtl/fmprt_pkg.sv
// ----------------------------------------------------------------------------
// fmprt_pkg
// Shared types, codes and the rule compare function of the first-match
// packet rule table.
// ----------------------------------------------------------------------------
`default_nettype none

package fmprt_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] cfg_index_t;

  localparam mode_t MODE_ADD   = 2'd0;
  localparam mode_t MODE_DEL   = 2'd1;
  localparam mode_t MODE_MATCH = 2'd2;

  localparam status_t STATUS_DONE      = 2'd0;
  localparam status_t STATUS_FULL      = 2'd1;
  localparam status_t STATUS_NOT_FOUND = 2'd2;

  localparam cfg_index_t CFG_DEFAULT_VERDICT   = 2'd0;
  localparam cfg_index_t CFG_WILDCARD_PROTOCOL = 2'd1;

  localparam logic [1:0] VERDICT_RESET  = 2'd1;
  localparam logic [7:0] WILDCARD_RESET = 8'd0;

  typedef struct packed {
    logic [15:0] ident;
    logic [1:0]  verdict;
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [31:0] dmask;
    logic [31:0] daddr;
    logic [31:0] smask;
    logic [31:0] saddr;
  } rule_t;

  function automatic logic addr_fits(logic [31:0] addr, logic [31:0] mask,
                                     logic [31:0] pkt);
    addr_fits = (addr == 32'd0) || ((pkt & mask) == (addr & mask));
  endfunction

  function automatic logic rule_fits(rule_t rule, rule_t pkt, logic [7:0] wild);
    rule_fits = ((rule.proto == wild) || (rule.proto == pkt.proto)) &&
                addr_fits(rule.saddr, rule.smask, pkt.saddr) &&
                addr_fits(rule.daddr, rule.dmask, pkt.daddr) &&
                ((rule.sport == 16'd0) || (rule.sport == pkt.sport)) &&
                ((rule.dport == 16'd0) || (rule.dport == pkt.dport));
  endfunction

endpackage

`default_nettype wire

// File: rtl/first_match_packet_rule_table_core.sv
// ----------------------------------------------------------------------------
// first_match_packet_rule_table_core
// Ordered packet filter rule table with add, delete by id and first-match
// lookup, held in one synchronous rule memory.
// ----------------------------------------------------------------------------
// Add and the unused mode give their result in the cycle after the word is taken.
// Match reads one rule per cycle through the single memory read port.
// Delete searches the same way, then moves each later rule down one place,
// one memory write per cycle.
// Reset clears the rule count and state and presets the config registers; rule memory and result fields are not reset.
// Results are strobed for one cycle and cannot be held off by the receiver.
`default_nettype none

module first_match_packet_rule_table_core #(
  parameter int RULE_DEPTH = 64
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire  fmprt_pkg::mode_t       mode_i,
  input  wire  [15:0]                  rule_ident_i,
  input  wire  [1:0]                   verdict_in_i,
  input  wire  [7:0]                   proto_code_i,
  input  wire  [31:0]                  source_addr_i,
  input  wire  [31:0]                  source_mask_i,
  input  wire  [31:0]                  dest_addr_i,
  input  wire  [31:0]                  dest_mask_i,
  input  wire  [15:0]                  source_port_num_i,
  input  wire  [15:0]                  dest_port_num_i,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  fmprt_pkg::cfg_index_t  cfg_index_i,
  input  wire  [7:0]                   cfg_data_i,
  output logic                         valid_o,
  output fmprt_pkg::status_t           status_o,
  output logic                         hit_o,
  output logic [15:0]                  hit_ident_o,
  output logic [1:0]                   verdict_out_o,
  output logic [6:0]                   rule_total_o
);

  import fmprt_pkg::*;

  localparam int IDX_W = $clog2(RULE_DEPTH);
  localparam int CNT_W = $clog2(RULE_DEPTH + 1);
  localparam int TOT_W = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RULE_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DEL   = 2'd2;
  localparam logic [1:0] ST_SHIFT = 2'd3;

  rule_t            mem_q [RULE_DEPTH];
  rule_t            rd_data_q;
  rule_t            key_q, key_d;
  rule_t            new_rule;
  rule_t            wr_data;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en, rd_en;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] wptr_q, wptr_d;
  logic             chk_q, chk_d;
  logic             issue;
  logic             fit;

  logic [1:0]       dflt_verdict_q;
  logic [7:0]       wild_proto_q;

  logic             valid_q, valid_d;
  status_t          status_q, status_d;
  logic             hit_q, hit_d;
  logic [15:0]      hit_ident_q, hit_ident_d;
  logic [1:0]       verdict_q, verdict_d;
  logic [TOT_W-1:0] total_w;

  assign new_rule = '{ident: rule_ident_i, verdict: verdict_in_i, proto: proto_code_i,
                      dport: dest_port_num_i, sport: source_port_num_i,
                      dmask: dest_mask_i, daddr: dest_addr_i,
                      smask: source_mask_i, saddr: source_addr_i};

  assign issue = (ptr_q < count_q);
  assign fit   = rule_fits(rd_data_q, key_q, wild_proto_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    wptr_d      = wptr_q;
    chk_d       = 1'b0;
    key_d       = key_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = wptr_q;
    wr_data     = rd_data_q;
    valid_d     = 1'b0;
    status_d    = status_q;
    hit_d       = hit_q;
    hit_ident_d = hit_ident_q;
    verdict_d   = verdict_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          key_d       = new_rule;
          ptr_d       = '0;
          status_d    = STATUS_DONE;
          hit_d       = 1'b0;
          hit_ident_d = 16'd0;
          verdict_d   = 2'd0;
          case (mode_i)
            MODE_ADD: begin
              valid_d = 1'b1;
              if (count_q == DEPTH_CNT) begin
                status_d = STATUS_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = count_q[IDX_W-1:0];
                wr_data = new_rule;
                count_d = count_q + 1'b1;
              end
            end
            MODE_DEL: begin
              if (count_q == '0) begin
                valid_d  = 1'b1;
                status_d = STATUS_NOT_FOUND;
              end else begin
                state_d = ST_DEL;
              end
            end
            MODE_MATCH: begin
              if (count_q == '0) begin
                valid_d   = 1'b1;
                verdict_d = dflt_verdict_q;
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_en = 1'b1;
          ptr_d = ptr_q + 1'b1;
          chk_d = 1'b1;
        end
        if (chk_q && fit) begin
          valid_d     = 1'b1;
          hit_d       = 1'b1;
          hit_ident_d = rd_data_q.ident;
          verdict_d   = rd_data_q.verdict;
          state_d     = ST_IDLE;
        end else if (!issue) begin
          valid_d   = 1'b1;
          verdict_d = dflt_verdict_q;
          state_d   = ST_IDLE;
        end
      end
      ST_DEL: begin
        if (issue) begin
          rd_en = 1'b1;
          ptr_d = ptr_q + 1'b1;
          chk_d = 1'b1;
        end
        if (chk_q && (rd_data_q.ident == key_q.ident)) begin
          wptr_d  = IDX_W'(ptr_q - 1'b1);
          state_d = ST_SHIFT;
        end else if (!issue) begin
          valid_d  = 1'b1;
          status_d = STATUS_NOT_FOUND;
          state_d  = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (issue) begin
          rd_en = 1'b1;
          ptr_d = ptr_q + 1'b1;
          chk_d = 1'b1;
        end
        if (chk_q) begin
          wr_en  = 1'b1;
          wptr_d = wptr_q + 1'b1;
        end else begin
          count_d = count_q - 1'b1;
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[ptr_q[IDX_W-1:0]];
    end
    key_q       <= key_d;
    wptr_q      <= wptr_d;
    hit_ident_q <= hit_ident_d;
    verdict_q   <= verdict_d;
    status_q    <= status_d;
    hit_q       <= hit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      ptr_q          <= '0;
      chk_q          <= 1'b0;
      valid_q        <= 1'b0;
      dflt_verdict_q <= VERDICT_RESET;
      wild_proto_q   <= WILDCARD_RESET;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      chk_q   <= chk_d;
      valid_q <= valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_DEFAULT_VERDICT) begin
          dflt_verdict_q <= cfg_data_i[1:0];
        end else if (cfg_index_i == CFG_WILDCARD_PROTOCOL) begin
          wild_proto_q <= cfg_data_i;
        end
      end
    end
  end

  assign total_w       = TOT_W'(count_q);
  assign busy_o        = (state_q != ST_IDLE);
  assign cfg_ready_o   = !busy_o && !start_i;
  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign hit_o         = hit_q;
  assign hit_ident_o   = hit_ident_q;
  assign verdict_out_o = verdict_q;
  assign rule_total_o  = total_w[6:0];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("rule count exceeds table depth");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == STATUS_FULL) |-> (count_q == DEPTH_CNT))
    else $error("full reported while table has room");

  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == MODE_ADD && count_q < DEPTH_CNT)
      |=> (count_q == $past(count_q) + 1'b1))
    else $error("add did not advance the rule count");

  a_scan_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && !issue && !chk_q) |-> 1'b0)
    else $error("lookup ran past the last rule");
`endif

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives add, delete, match and unused-mode words and config writes into the rule table, keeps
// its own ordered copy of the rules and the two registers, and checks every
// strobed result field by field against the outcome predicted at acceptance.
// ----------------------------------------------------------------------------

module testbench;

  import fmprt_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam mode_t MODE_UNUSED = 2'd3;
  localparam cfg_index_t CFG_UNUSED = 2'd3;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] ident;
    logic [1:0]  verdict;
    logic [7:0]  proto;
    logic [31:0] saddr;
    logic [31:0] smask;
    logic [31:0] daddr;
    logic [31:0] dmask;
    logic [15:0] sport;
    logic [15:0] dport;
  } packet_word_t;

  typedef struct packed {
    status_t     status;
    logic        hit;
    logic [15:0] ident;
    logic [1:0]  verdict;
    logic [6:0]  total;
  } outcome_t;

  typedef enum logic [1:0] {STEP_WORD, STEP_CFG, STEP_DRAIN} step_kind_e;

  typedef struct packed {
    step_kind_e   kind;
    logic [6:0]   idle_pct;
    packet_word_t word;
    cfg_index_t   cfg_idx;
    logic [7:0]   cfg_data;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  mode_t       mode_i = MODE_ADD;
  logic [15:0] rule_ident_i = '0;
  logic [1:0]  verdict_in_i = '0;
  logic [7:0]  proto_code_i = '0;
  logic [31:0] source_addr_i = '0;
  logic [31:0] source_mask_i = '0;
  logic [31:0] dest_addr_i = '0;
  logic [31:0] dest_mask_i = '0;
  logic [15:0] source_port_num_i = '0;
  logic [15:0] dest_port_num_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_index_t  cfg_index_i = CFG_DEFAULT_VERDICT;
  logic [7:0]  cfg_data_i = '0;
  logic        valid_o;
  status_t     status_o;
  logic        hit_o;
  logic [15:0] hit_ident_o;
  logic [1:0]  verdict_out_o;
  logic [6:0]  rule_total_o;

  step_t        work_q[$];
  outcome_t     outcomes_due[$];
  packet_word_t stored_rules[$];
  packet_word_t cur_word = '0;
  cfg_index_t   cur_cfg_idx = CFG_DEFAULT_VERDICT;
  logic [7:0]   cur_cfg_data = '0;
  logic [1:0]   miss_verdict = VERDICT_RESET;
  logic [7:0]   any_proto = WILDCARD_RESET;
  int unsigned  mismatch_count = 0;

  first_match_packet_rule_table_core #(
    .RULE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .mode_i(mode_i),
    .rule_ident_i(rule_ident_i),
    .verdict_in_i(verdict_in_i),
    .proto_code_i(proto_code_i),
    .source_addr_i(source_addr_i),
    .source_mask_i(source_mask_i),
    .dest_addr_i(dest_addr_i),
    .dest_mask_i(dest_mask_i),
    .source_port_num_i(source_port_num_i),
    .dest_port_num_i(dest_port_num_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .valid_o(valid_o),
    .status_o(status_o),
    .hit_o(hit_o),
    .hit_ident_o(hit_ident_o),
    .verdict_out_o(verdict_out_o),
    .rule_total_o(rule_total_o)
  );

  function automatic logic addr_covers(logic [31:0] addr, logic [31:0] mask,
                                       logic [31:0] pkt);
    return (addr == 32'd0) || ((pkt & mask) == (addr & mask));
  endfunction

  // Applies one word to the rule list and returns the result it must produce.
  function automatic outcome_t table_outcome(packet_word_t w);
    outcome_t     o;
    packet_word_t r;
    int           i;
    o = '0;
    case (w.mode)
      MODE_ADD: begin
        if (stored_rules.size() >= TABLE_DEPTH) begin
          o.status = STATUS_FULL;
        end else begin
          stored_rules.push_back(w);
        end
      end
      MODE_DEL: begin
        o.status = STATUS_NOT_FOUND;
        for (i = 0; i < stored_rules.size(); i++) begin
          if (stored_rules[i].ident == w.ident) begin
            stored_rules.delete(i);
            o.status = STATUS_DONE;
            break;
          end
        end
      end
      MODE_MATCH: begin
        o.verdict = miss_verdict;
        for (i = 0; i < stored_rules.size(); i++) begin
          r = stored_rules[i];
          if ((r.proto == any_proto || r.proto == w.proto) &&
              addr_covers(r.saddr, r.smask, w.saddr) &&
              addr_covers(r.daddr, r.dmask, w.daddr) &&
              (r.sport == 16'd0 || r.sport == w.sport) &&
              (r.dport == 16'd0 || r.dport == w.dport)) begin
            o.hit = 1'b1;
            o.ident = r.ident;
            o.verdict = r.verdict;
            break;
          end
        end
      end
      default: begin
      end
    endcase
    o.total = 7'(stored_rules.size());
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("MISMATCH at %0t ns: %s", $realtime, msg);
    end
  endtask

  function automatic packet_word_t make_word(mode_t m, logic [15:0] id, logic [1:0] v,
                                             logic [7:0] p, logic [31:0] sa,
                                             logic [31:0] sm, logic [31:0] da,
                                             logic [31:0] dm, logic [15:0] sp,
                                             logic [15:0] dp);
    packet_word_t w;
    w.mode = m;
    w.ident = id;
    w.verdict = v;
    w.proto = p;
    w.saddr = sa;
    w.smask = sm;
    w.daddr = da;
    w.dmask = dm;
    w.sport = sp;
    w.dport = dp;
    return w;
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 9))
      0, 1: return 8'd6;
      2, 3: return 8'd17;
      4:    return 8'd1;
      5:    return 8'd0;
      6:    return 8'd255;
      7:    return 8'd6;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] pick_addr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 32'd0;
    if (r < 70) return 32'h0A00_0000 | ($urandom_range(0, 3) << 8) | $urandom_range(0, 3);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_mask();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 32'd0;
    if (r < 55) return 32'hFFFF_FF00;
    if (r < 75) return 32'hFFFF_FFFF;
    if (r < 85) return 32'hFFFF_0000;
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_port();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 16'd0;
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0: return 16'd22;
        1: return 16'd53;
        2: return 16'd80;
        default: return 16'd443;
      endcase
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // Filling stretches favour adds; draining ones favour deletes.
  function automatic packet_word_t rand_word(bit filling);
    packet_word_t w;
    int unsigned  r;
    r = $urandom_range(0, 99);
    if (filling) begin
      w.mode = (r < 58) ? MODE_ADD : (r < 68) ? MODE_DEL : (r < 98) ? MODE_MATCH : MODE_UNUSED;
    end else begin
      w.mode = (r < 10) ? MODE_ADD : (r < 60) ? MODE_DEL : (r < 98) ? MODE_MATCH : MODE_UNUSED;
    end
    w.ident = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 23))
                                           : 16'($urandom_range(0, 65535));
    w.verdict = 2'($urandom_range(0, 3));
    w.proto = pick_proto();
    w.saddr = pick_addr();
    w.smask = pick_mask();
    w.daddr = pick_addr();
    w.dmask = pick_mask();
    w.sport = pick_port();
    w.dport = pick_port();
    return w;
  endfunction

  task automatic push_word(packet_word_t w, int unsigned pct);
    step_t s;
    s = '0;
    s.kind = STEP_WORD;
    s.idle_pct = 7'(pct);
    s.word = w;
    work_q.push_back(s);
  endtask

  task automatic push_drain();
    step_t s;
    s = '0;
    s.kind = STEP_DRAIN;
    work_q.push_back(s);
  endtask

  task automatic push_cfg(cfg_index_t idx, logic [7:0] data);
    step_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.cfg_idx = idx;
    s.cfg_data = data;
    push_drain();
    work_q.push_back(s);
  endtask

  task automatic push_random(int unsigned first, int unsigned count, int unsigned pct);
    int unsigned n;
    for (n = first; n < first + count; n++) begin
      if (n % 300 == 150) begin
        push_drain();
      end
      push_word(rand_word((n / 100) % 3 != 2), pct);
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    bit    word_on;
    bit    cfg_on;
    step_t head;
    if (!rst_ni) begin
      start_i <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      word_on = start_i;
      cfg_on = cfg_valid_i;
      if (start_i && !busy_o) begin
        outcomes_due.push_back(table_outcome(cur_word));
        word_on = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cur_cfg_idx == CFG_DEFAULT_VERDICT) begin
          miss_verdict = cur_cfg_data[1:0];
        end else if (cur_cfg_idx == CFG_WILDCARD_PROTOCOL) begin
          any_proto = cur_cfg_data;
        end
        cfg_on = 1'b0;
      end
      if (!word_on && !cfg_on && work_q.size() != 0) begin
        head = work_q[0];
        case (head.kind)
          STEP_WORD: begin
            if ($urandom_range(0, 99) >= head.idle_pct) begin
              head = work_q.pop_front();
              cur_word = head.word;
              word_on = 1'b1;
            end
          end
          STEP_CFG: begin
            head = work_q.pop_front();
            cur_cfg_idx = head.cfg_idx;
            cur_cfg_data = head.cfg_data;
            cfg_on = 1'b1;
          end
          default: begin
            if (outcomes_due.size() == 0 && !busy_o) begin
              head = work_q.pop_front();
            end
          end
        endcase
      end
      start_i <= word_on;
      cfg_valid_i <= cfg_on;
      cfg_index_i <= cur_cfg_idx;
      cfg_data_i <= cur_cfg_data;
      mode_i <= cur_word.mode;
      rule_ident_i <= cur_word.ident;
      verdict_in_i <= cur_word.verdict;
      proto_code_i <= cur_word.proto;
      source_addr_i <= cur_word.saddr;
      source_mask_i <= cur_word.smask;
      dest_addr_i <= cur_word.daddr;
      dest_mask_i <= cur_word.dmask;
      source_port_num_i <= cur_word.sport;
      dest_port_num_i <= cur_word.dport;
    end
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && valid_o) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch("result word with no operation pending");
      end else begin
        want = outcomes_due.pop_front();
        if (status_o !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        end
        if (hit_o !== want.hit) begin
          report_mismatch($sformatf("hit %0d, expected %0d", hit_o, want.hit));
        end
        if (hit_ident_o !== want.ident) begin
          report_mismatch($sformatf("hit_ident %h, expected %h", hit_ident_o, want.ident));
        end
        if (verdict_out_o !== want.verdict) begin
          report_mismatch($sformatf("verdict %0d, expected %0d", verdict_out_o,
                                    want.verdict));
        end
        if (rule_total_o !== want.total) begin
          report_mismatch($sformatf("rule_total %0d, expected %0d", rule_total_o,
                                    want.total));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    push_cfg(CFG_DEFAULT_VERDICT, 8'h00);
    push_cfg(CFG_WILDCARD_PROTOCOL, 8'h00);
    push_word(make_word(MODE_MATCH, 16'd0, 2'd0, 8'd6, 32'd0, 32'd0, 32'd0, 32'd0,
                        16'd0, 16'd0), 36);
    push_word(make_word(MODE_DEL, 16'd5, 2'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                        16'd0, 16'd0), 36);
    push_word(make_word(MODE_UNUSED, 16'd0, 2'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                        16'd0, 16'd0), 36);
    push_word(make_word(MODE_ADD, 16'hFFFF, 2'd3, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                        16'd0, 16'd0), 36);
    push_word(make_word(MODE_MATCH, 16'hFFFF, 2'd3, 8'hFF, '1, '1, '1, '1,
                        16'hFFFF, 16'hFFFF), 36);
    push_word(make_word(MODE_ADD, 16'd0, 2'd0, 8'hFF, '1, '1, 32'd1, 32'd0,
                        16'hFFFF, 16'hFFFF), 36);
    push_word(make_word(MODE_DEL, 16'hFFFF, 2'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                        16'd0, 16'd0), 36);
    push_word(make_word(MODE_MATCH, 16'd0, 2'd0, 8'hFF, '1, 32'd0, 32'd0, 32'd0,
                        16'hFFFF, 16'hFFFF), 36);
    push_word(make_word(MODE_MATCH, 16'd0, 2'd0, 8'hFF, 32'hFFFF_FFFE, 32'd0, 32'd0,
                        32'd0, 16'hFFFF, 16'hFFFF), 36);
    push_word(make_word(MODE_MATCH, 16'd0, 2'd0, 8'hFF, '1, 32'd0, 32'd0, 32'd0,
                        16'hFFFE, 16'hFFFF), 36);
    push_word(make_word(MODE_ADD, 16'h1234, 2'd2, 8'd17, 32'h0A00_0001, 32'hFFFF_FF00,
                        32'd0, '1, 16'd0, 16'd53), 36);
    push_word(make_word(MODE_ADD, 16'h1234, 2'd1, 8'd17, 32'd0, 32'd0, 32'd0, 32'd0,
                        16'd0, 16'd0), 36);
    push_word(make_word(MODE_MATCH, 16'd0, 2'd0, 8'd17, 32'h0A00_00FE, 32'd0,
                        32'h0102_0304, 32'd0, 16'd1234, 16'd53), 36);
    push_word(make_word(MODE_DEL, 16'h1234, 2'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                        16'd0, 16'd0), 36);
    push_word(make_word(MODE_MATCH, 16'd0, 2'd0, 8'd17, 32'h0A00_00FE, 32'd0,
                        32'h0102_0304, 32'd0, 16'd1234, 16'd53), 36);
    push_word(make_word(MODE_MATCH, 16'd0, 2'd0, 8'd6, 32'h0A00_00FE, 32'd0,
                        32'h0102_0304, 32'd0, 16'd1234, 16'd53), 36);
    push_word(make_word(MODE_DEL, 16'h1234, 2'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                        16'd0, 16'd0), 36);
    push_word(make_word(MODE_DEL, 16'h1234, 2'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                        16'd0, 16'd0), 36);
    push_word(make_word(MODE_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1, '1), 36);
    push_word(make_word(MODE_ADD, 16'hAAAA, 2'd1, 8'h5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                        32'h5A5A_5A5A, 32'hA5A5_A5A5, 16'h5555, 16'hAAAA), 36);
    push_word(make_word(MODE_MATCH, 16'd0, 2'd0, 8'h5A, 32'h0000_A5A5, 32'd0,
                        32'h5A5A_0000, 32'd0, 16'h5555, 16'hAAAA), 36);
    push_word(make_word(MODE_DEL, 16'd0, 2'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                        16'd0, 16'd0), 36);
    push_random(0, 300, 36);

    push_cfg(CFG_DEFAULT_VERDICT, 8'hFF);
    push_cfg(CFG_WILDCARD_PROTOCOL, 8'hFF);
    push_cfg(CFG_UNUSED, 8'h5A);
    push_random(300, 300, 53);

    push_cfg(CFG_DEFAULT_VERDICT, 8'h02);
    push_cfg(CFG_WILDCARD_PROTOCOL, 8'd6);
    push_random(600, 300, 0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    do begin
      @(posedge clk_i);
    end while (work_q.size() != 0 || start_i || cfg_valid_i || outcomes_due.size() != 0);
    repeat (80) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
